// ----- src/ppts_pkg.sv -----
// Package with the request, result and memory entry types of the processor pool task scheduler.
package ppts_pkg;

  localparam int unsigned NEED_W     = 7;
  localparam int unsigned DUR_W      = 5;
  localparam int unsigned PRIO_W     = 2;
  localparam int unsigned CNT_W      = 32;
  localparam logic [DUR_W-1:0]  MaxDuration = 5'd20;
  localparam logic [PRIO_W-1:0] PrioBlock   = 2'd3;

  typedef enum logic [1:0] {
    STATUS_QUEUED  = 2'd0,
    STATUS_REFUSED = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_TICK    = 2'd3
  } status_e;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_SUBMIT = 1'b1
  } op_e;

  typedef struct packed {
    logic              operation;
    logic [NEED_W-1:0] task_processors;
    logic [DUR_W-1:0]  task_duration;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [6:0]        free_processors;
    logic [4:0]        queue_length;
    logic [6:0]        running_count;
    logic [4:0]        started_now;
    logic [6:0]        finished_now;
    logic [CNT_W-1:0]  tick_total;
    logic [CNT_W-1:0]  idle_total;
    logic [CNT_W-1:0]  completed_total;
    logic [CNT_W-1:0]  refusal_total;
  } res_t;

  typedef struct packed {
    logic [NEED_W-1:0] need;
    logic [DUR_W-1:0]  dur;
    logic [PRIO_W-1:0] prio;
  } wait_t;

  typedef struct packed {
    logic [NEED_W-1:0] need;
    logic [CNT_W-1:0]  due;
  } run_t;

endpackage

// ----- src/processor_pool_task_scheduler.sv -----
// Top level of the processor pool task scheduler: queue and run slot memories with their sequencer.
//
// A request is taken at a rising edge with start high and busy low. It either submits
// a task (need and duration) or lets one tick pass. Every request produces exactly one
// result on result_o, shown for one cycle with result_valid_o high; the receiver cannot
// hold results off, so nothing waits on the output side.
// A submission is checked and appended to the waiting queue as it is taken; its result
// appears in the cycle after the request and busy never rises for it.
// A tick walks the run slot memory once, one slot per cycle, to free the tasks that are
// due. It then walks the waiting queue in order, reading each entry and then evaluating
// it, compacting the queue in place as started tasks leave it. Each start claims a run
// slot after the slot pointer steps past every occupied slot ahead of it; that pointer
// only moves forward within a tick, so it never steps past the last slot. A closing
// state ends the tick, and the tick's result shows in the first cycle with busy low.
// The pool size register is written over the cfg channel while the block is idle; free
// processors are recomputed from a running sum of the needs of running tasks.
// Reset empties the queue, clears every run slot valid bit, zeroes the counters and sets
// the pool to 16 processors. No memory clearing pass is needed.
module processor_pool_task_scheduler #(
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned RUN_SLOTS      = 64,
  parameter int unsigned MAX_PROCESSORS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ppts_pkg::req_t    req_i,
  output logic              result_valid_o,
  output ppts_pkg::res_t    result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [6:0]        cfg_data_i
);
  import ppts_pkg::*;

  localparam int unsigned QW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW   = $clog2(RUN_SLOTS);
  localparam int unsigned RCW  = $clog2(RUN_SLOTS + 1);
  localparam int unsigned BW0  = $clog2(RUN_SLOTS * MAX_PROCESSORS + 1);
  localparam int unsigned BW   = (BW0 > NEED_W) ? BW0 : NEED_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_REL  = 6'b000010,
    ST_QRD  = 6'b000100,
    ST_QEV  = 6'b001000,
    ST_SEEK = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e state_q;

  // Architectural state held in flip-flops.
  logic [NEED_W-1:0]    total_q, free_q;
  logic [QCW-1:0]       count_q;
  logic [RUN_SLOTS-1:0] valid_q;
  logic [RCW-1:0]       running_q;
  logic [BW-1:0]        busy_sum_q;
  logic [CNT_W-1:0]     tick_q, idle_q, done_q, refused_q;

  // Per tick sequencing state.
  logic [RCW-1:0]       rel_cnt_q;
  logic [QCW-1:0]       rd_idx_q, wr_idx_q;
  logic [SW-1:0]        ptr_q;
  logic                 blocked_q;
  wait_t                ent_q;
  logic [4:0]           started_q;
  logic [6:0]           finished_q;

  res_t                 res_q;
  logic                 res_vld_q;

  // Memories.
  wait_t                q_mem [QUEUE_DEPTH];
  run_t                 r_mem [RUN_SLOTS];
  wait_t                q_rdata, q_wdata;
  run_t                 r_rdata, r_wdata;
  logic                 q_we, r_we;
  logic [QW-1:0]        q_waddr, q_raddr;
  logic [SW-1:0]        r_waddr, r_raddr;

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata <= q_mem[q_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      r_mem[r_waddr] <= r_wdata;
    end
    r_rdata <= r_mem[r_raddr];
  end

  logic accept, sub_bad, sub_full, sub_ok;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign accept      = start && !busy;
  assign sub_bad  = (req_i.task_processors > total_q) || (req_i.task_duration > MaxDuration);
  assign sub_full = (count_q == QCW'(QUEUE_DEPTH));
  assign sub_ok   = accept && (req_i.operation == OP_SUBMIT) && !sub_bad && !sub_full;

  // Release check of the slot whose data returns this cycle.
  logic [SW-1:0]   chk_idx;
  logic            rel_hit, rel_end;
  logic [NEED_W:0] rel_sum;
  logic [NEED_W-1:0] rel_free;
  assign chk_idx  = SW'(rel_cnt_q - RCW'(1));
  assign rel_hit  = (rel_cnt_q != '0) && valid_q[chk_idx] && (r_rdata.due == tick_q);
  assign rel_end  = (rel_cnt_q == RCW'(RUN_SLOTS));
  assign rel_sum  = {1'b0, free_q} + {1'b0, r_rdata.need};
  assign rel_free = (rel_sum > {1'b0, total_q}) ? total_q : rel_sum[NEED_W-1:0];

  // Queue scan decision.
  logic fits, last_ent;
  wait_t keep_ent;
  assign fits     = (q_rdata.need <= free_q) && (running_q != RCW'(RUN_SLOTS));
  assign last_ent = ((rd_idx_q + QCW'(1)) == count_q);
  always_comb begin
    keep_ent = q_rdata;
    if (!blocked_q && (q_rdata.prio < PrioBlock)) begin
      keep_ent.prio = q_rdata.prio + PRIO_W'(1);
    end
  end

  logic [DUR_W-1:0] run_dur;
  assign run_dur = (ent_q.dur == '0) ? DUR_W'(1) : ent_q.dur;

  // Configuration clamp and free recomputation.
  logic [NEED_W-1:0] cfg_tot, cfg_free;
  always_comb begin
    cfg_tot = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_tot = NEED_W'(1);
    end else if (32'(cfg_data_i) > MAX_PROCESSORS) begin
      cfg_tot = NEED_W'(MAX_PROCESSORS);
    end
    cfg_free = (BW'(cfg_tot) > busy_sum_q) ? NEED_W'(BW'(cfg_tot) - busy_sum_q) : '0;
  end

  always_comb begin
    q_we    = 1'b0;
    q_waddr = QW'(count_q);
    q_wdata = '{need: req_i.task_processors, dur: req_i.task_duration, prio: '0};
    q_raddr = QW'(rd_idx_q);
    r_we    = 1'b0;
    r_waddr = ptr_q;
    r_wdata = '{need: ent_q.need, due: tick_q + CNT_W'(run_dur)};
    r_raddr = (rel_cnt_q < RCW'(RUN_SLOTS)) ? SW'(rel_cnt_q) : '0;
    case (state_q)
      ST_IDLE: begin
        q_we = sub_ok;
      end
      ST_QEV: begin
        if (blocked_q || !fits) begin
          q_we    = 1'b1;
          q_waddr = QW'(wr_idx_q);
          q_wdata = keep_ent;
        end
      end
      ST_SEEK: begin
        r_we = !valid_q[ptr_q];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      total_q    <= NEED_W'(16);
      free_q     <= NEED_W'(16);
      count_q    <= '0;
      valid_q    <= '0;
      running_q  <= '0;
      busy_sum_q <= '0;
      tick_q     <= '0;
      idle_q     <= '0;
      done_q     <= '0;
      refused_q  <= '0;
      rel_cnt_q  <= '0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      ptr_q      <= '0;
      blocked_q  <= 1'b0;
      ent_q      <= '0;
      started_q  <= '0;
      finished_q <= '0;
      res_q      <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cfg_valid_i) begin
            total_q <= cfg_tot;
            free_q  <= cfg_free;
          end
          if (accept) begin
            if (req_i.operation == OP_SUBMIT) begin
              res_vld_q             <= 1'b1;
              res_q.free_processors <= free_q;
              res_q.running_count   <= 7'(running_q);
              res_q.started_now     <= '0;
              res_q.finished_now    <= '0;
              res_q.tick_total      <= tick_q;
              res_q.idle_total      <= idle_q;
              res_q.completed_total <= done_q;
              if (sub_bad) begin
                res_q.status        <= STATUS_INVALID;
                res_q.queue_length  <= 5'(count_q);
                res_q.refusal_total <= refused_q;
              end else if (sub_full) begin
                res_q.status        <= STATUS_REFUSED;
                res_q.queue_length  <= 5'(count_q);
                refused_q           <= refused_q + CNT_W'(1);
                res_q.refusal_total <= refused_q + CNT_W'(1);
              end else begin
                res_q.status        <= STATUS_QUEUED;
                count_q             <= count_q + QCW'(1);
                res_q.queue_length  <= 5'(count_q + QCW'(1));
                res_q.refusal_total <= refused_q;
              end
            end else begin
              state_q    <= ST_REL;
              rel_cnt_q  <= '0;
              started_q  <= '0;
              finished_q <= '0;
            end
          end
        end
        ST_REL: begin
          if (rel_hit) begin
            valid_q[chk_idx] <= 1'b0;
            free_q           <= rel_free;
            busy_sum_q       <= busy_sum_q - BW'(r_rdata.need);
            running_q        <= running_q - RCW'(1);
            done_q           <= done_q + CNT_W'(1);
            finished_q       <= finished_q + 7'd1;
          end
          rel_cnt_q <= rel_cnt_q + RCW'(1);
          if (rel_end) begin
            rd_idx_q  <= '0;
            wr_idx_q  <= '0;
            ptr_q     <= '0;
            blocked_q <= 1'b0;
            state_q   <= (count_q == '0) ? ST_FIN : ST_QRD;
          end
        end
        ST_QRD: begin
          state_q <= ST_QEV;
        end
        ST_QEV: begin
          ent_q <= q_rdata;
          if (!blocked_q && fits) begin
            state_q <= ST_SEEK;
          end else begin
            if (!blocked_q && (q_rdata.prio >= PrioBlock)) begin
              blocked_q <= 1'b1;
            end
            wr_idx_q <= wr_idx_q + QCW'(1);
            rd_idx_q <= rd_idx_q + QCW'(1);
            if (last_ent) begin
              count_q <= wr_idx_q + QCW'(1);
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_QRD;
            end
          end
        end
        ST_SEEK: begin
          if (!valid_q[ptr_q]) begin
            valid_q[ptr_q] <= 1'b1;
            free_q         <= free_q - ent_q.need;
            busy_sum_q     <= busy_sum_q + BW'(ent_q.need);
            running_q      <= running_q + RCW'(1);
            started_q      <= started_q + 5'd1;
            rd_idx_q       <= rd_idx_q + QCW'(1);
            if (last_ent) begin
              count_q <= wr_idx_q;
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_QRD;
            end
          end else begin
            ptr_q <= ptr_q + SW'(1);
          end
        end
        ST_FIN: begin
          res_vld_q             <= 1'b1;
          res_q.status          <= STATUS_TICK;
          res_q.free_processors <= free_q;
          res_q.queue_length    <= 5'(count_q);
          res_q.running_count   <= 7'(running_q);
          res_q.started_now     <= started_q;
          res_q.finished_now    <= finished_q;
          res_q.tick_total      <= tick_q + CNT_W'(1);
          res_q.idle_total      <= (running_q == '0) ? idle_q + CNT_W'(1) : idle_q;
          res_q.completed_total <= done_q;
          res_q.refusal_total   <= refused_q;
          tick_q                <= tick_q + CNT_W'(1);
          if (running_q == '0) begin
            idle_q <= idle_q + CNT_W'(1);
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // The running count always matches the number of occupied run slots.
  a_running_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(running_q)) else $error("running count mismatch");

  // Free processors never exceed the pool size.
  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= total_q) else $error("free processors above pool size");

  // Queue compaction never writes ahead of the read position.
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QEV || state_q == ST_SEEK) |-> (wr_idx_q <= rd_idx_q))
    else $error("queue compaction overtook the scan");

  // A tick request always ends in a result before the block takes another request.
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o) else $error("tick finished without a result");

endmodule

// ----- tb/processor_pool_task_scheduler_tb.sv -----
// Self-checking testbench of the processor pool task scheduler.
//
// Each accepted request is run through a behavioral model of the scheduler that is kept
// inside this file: pool size, waiting queue with priorities, run slots and counters.
// The model's result is appended to a queue, and every result strobe from the block is
// compared field by field with the oldest entry. A short table of directed requests runs
// first: reset state, field extremes, invalid and refused submissions, zero need and zero
// duration tasks, and the priority block. Random phases follow, each under its own pool
// size, the clamped extremes among them. Random gaps on the request side land on every
// phase of a tick's scan; the last phase runs back to back.
module processor_pool_task_scheduler_tb;
  import ppts_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned NSLOTS = 64;
  localparam int unsigned MAXPROC = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic result_valid_o;
  res_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [6:0] cfg_data_i = '0;

  processor_pool_task_scheduler DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .result_valid_o(result_valid_o), .result_o(result_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state of the scheduler.
  int unsigned pool_size;
  int unsigned wait_need[QDEPTH];
  int unsigned wait_dur[QDEPTH];
  int unsigned wait_prio[QDEPTH];
  int unsigned wait_len;
  int unsigned slot_need[NSLOTS];
  logic [31:0] slot_due[NSLOTS];
  bit slot_busy[NSLOTS];
  int unsigned free_procs;
  logic [31:0] ticks, idles, completions, refusals;

  // Expected results; a typed status from the directed table rides along.
  res_t expected_results[$];
  bit status_typed[$];
  status_e typed_status[$];
  int unsigned mismatches = 0;

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, field, got, want);
  endtask

  function automatic int unsigned count_running();
    int unsigned n;
    n = 0;
    foreach (slot_busy[i]) if (slot_busy[i]) n++;
    return n;
  endfunction

  task automatic model_reset();
    pool_size = 16;
    wait_len = 0;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    free_procs = 16;
    ticks = '0;
    idles = '0;
    completions = '0;
    refusals = '0;
  endtask

  task automatic model_config(logic [6:0] data);
    int unsigned held;
    int unsigned v;
    held = 0;
    v = data;
    if (v < 1) v = 1;
    if (v > MAXPROC) v = MAXPROC;
    pool_size = v;
    foreach (slot_busy[i]) if (slot_busy[i]) held += slot_need[i];
    free_procs = (pool_size > held) ? pool_size - held : 0;
  endtask

  // Works out the result of one accepted request and advances the model.
  task automatic schedule_request(req_t r, output res_t res);
    status_e st;
    int unsigned started, finished, i, slot;
    started = 0;
    finished = 0;
    if (op_e'(r.operation) == OP_SUBMIT) begin
      if (r.task_processors > pool_size || r.task_duration > MaxDuration) begin
        st = STATUS_INVALID;
      end else if (wait_len >= QDEPTH) begin
        refusals++;
        st = STATUS_REFUSED;
      end else begin
        wait_need[wait_len] = r.task_processors;
        wait_dur[wait_len] = r.task_duration;
        wait_prio[wait_len] = 0;
        wait_len++;
        st = STATUS_QUEUED;
      end
    end else begin
      // Release every running task that is due at this tick.
      for (int k = 0; k < NSLOTS; k++) begin
        if (slot_busy[k] && slot_due[k] == ticks) begin
          slot_busy[k] = 1'b0;
          free_procs += slot_need[k];
          if (free_procs > pool_size) free_procs = pool_size;
          completions++;
          finished++;
        end
      end
      // Scan the queue in order; a started task leaves and the rest close up behind it.
      i = 0;
      while (i < wait_len) begin
        slot = NSLOTS;
        for (int k = NSLOTS - 1; k >= 0; k--) if (!slot_busy[k]) slot = k;
        if (wait_need[i] <= free_procs && slot < NSLOTS) begin
          slot_need[slot] = wait_need[i];
          slot_due[slot] = ticks + ((wait_dur[i] == 0) ? 1 : wait_dur[i]);
          slot_busy[slot] = 1'b1;
          free_procs -= wait_need[i];
          for (int k = i; k + 1 < wait_len; k++) begin
            wait_need[k] = wait_need[k+1];
            wait_dur[k] = wait_dur[k+1];
            wait_prio[k] = wait_prio[k+1];
          end
          wait_len--;
          started++;
        end else if (wait_prio[i] >= PrioBlock) begin
          break;
        end else begin
          wait_prio[i]++;
          i++;
        end
      end
      if (count_running() == 0) idles++;
      ticks++;
      st = STATUS_TICK;
    end
    res.status = st;
    res.free_processors = 7'(free_procs);
    res.queue_length = 5'(wait_len);
    res.running_count = 7'(count_running());
    res.started_now = 5'(started);
    res.finished_now = 7'(finished);
    res.tick_total = ticks;
    res.idle_total = idles;
    res.completed_total = completions;
    res.refusal_total = refusals;
  endtask

  // Result checker: the receiver cannot stall, so every strobe is one result.
  always @(posedge clk_i) begin
    res_t want;
    bit typed;
    status_e tst;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        want = expected_results.pop_front();
        typed = status_typed.pop_front();
        tst = typed_status.pop_front();
        if (typed && result_o.status != tst)
          report_mismatch("status (directed)", result_o.status, tst);
        if (result_o.status != want.status)
          report_mismatch("status", result_o.status, want.status);
        if (result_o.free_processors != want.free_processors)
          report_mismatch("free_processors", result_o.free_processors, want.free_processors);
        if (result_o.queue_length != want.queue_length)
          report_mismatch("queue_length", result_o.queue_length, want.queue_length);
        if (result_o.running_count != want.running_count)
          report_mismatch("running_count", result_o.running_count, want.running_count);
        if (result_o.started_now != want.started_now)
          report_mismatch("started_now", result_o.started_now, want.started_now);
        if (result_o.finished_now != want.finished_now)
          report_mismatch("finished_now", result_o.finished_now, want.finished_now);
        if (result_o.tick_total != want.tick_total)
          report_mismatch("tick_total", result_o.tick_total, want.tick_total);
        if (result_o.idle_total != want.idle_total)
          report_mismatch("idle_total", result_o.idle_total, want.idle_total);
        if (result_o.completed_total != want.completed_total)
          report_mismatch("completed_total", result_o.completed_total, want.completed_total);
        if (result_o.refusal_total != want.refusal_total)
          report_mismatch("refusal_total", result_o.refusal_total, want.refusal_total);
      end
    end
  end

  // Drives one request and returns at the edge that takes it. Start stays high, so the
  // caller either sends the next request in the same time step or opens a gap.
  task automatic send_request(op_e op, logic [6:0] need, logic [4:0] dur,
                              bit typed, status_e st);
    req_t r;
    res_t res;
    r.operation = op;
    r.task_processors = need;
    r.task_duration = dur;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    schedule_request(r, res);
    expected_results = {expected_results, res};
    status_typed = {status_typed, typed};
    typed_status = {typed_status, st};
  endtask

  task automatic hold_off(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Waits until every expected result is in and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0 || busy);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_pool_size(logic [6:0] data);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_config(data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  typedef struct {
    op_e op;
    logic [6:0] need;
    logic [4:0] dur;
    int unsigned reps;
    bit typed;
    status_e st;
  } table_row_t;

  // Directed requests under the reset pool of 16 processors.
  table_row_t directed_rows[] = '{
    '{OP_TICK,   7'd0,   5'd0,  1, 1'b1, STATUS_TICK},     // empty scheduler after reset
    '{OP_SUBMIT, 7'd17,  5'd1,  1, 1'b1, STATUS_INVALID},  // needs more than the pool
    '{OP_SUBMIT, 7'd16,  5'd21, 1, 1'b1, STATUS_INVALID},  // runs too long
    '{OP_SUBMIT, 7'd127, 5'd31, 1, 1'b1, STATUS_INVALID},  // both fields at their top
    '{OP_SUBMIT, 7'd0,   5'd0,  1, 1'b1, STATUS_QUEUED},   // zero need and zero duration
    '{OP_SUBMIT, 7'd16,  5'd20, 1, 1'b1, STATUS_QUEUED},   // whole pool, longest run
    '{OP_SUBMIT, 7'd5,   5'd0,  1, 1'b1, STATUS_QUEUED},
    '{OP_TICK,   7'd0,   5'd0,  2, 1'b1, STATUS_TICK},
    '{OP_SUBMIT, 7'd16,  5'd20, 15, 1'b0, STATUS_QUEUED},  // fill the queue
    '{OP_SUBMIT, 7'd1,   5'd1,  2, 1'b1, STATUS_REFUSED},  // queue is full
    '{OP_TICK,   7'd127, 5'd31, 4, 1'b1, STATUS_TICK}      // priorities climb to the block
  };

  initial begin
    logic [6:0] pool_values[6];
    logic [6:0] need;
    logic [4:0] dur;
    int unsigned pool;
    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      repeat (directed_rows[r].reps)
        send_request(directed_rows[r].op, directed_rows[r].need, directed_rows[r].dur,
                     directed_rows[r].typed, directed_rows[r].st);

    // Pool sizes per phase: zero and the top code clamp to the extremes.
    pool_values = '{7'd16, 7'd1, 7'd127, 7'd0, 7'd64, 7'($urandom_range(2, 63))};
    for (int p = 0; p < 6; p++) begin
      drain();
      write_pool_size(pool_values[p]);
      pool = pool_size;
      for (int n = 0; n < 290; n++) begin
        if (p < 5 && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 14));
        // Once, the sender waits for every outstanding result mid-phase.
        if (p == 2 && n == 150) drain();
        need = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, pool));
        dur = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 20));
        if ($urandom_range(0, 99) < 45)
          send_request(OP_TICK, 7'($urandom), 5'($urandom), 1'b0, STATUS_TICK);
        else
          send_request(OP_SUBMIT, need, dur, 1'b0, STATUS_QUEUED);
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
src/ppts_pkg.sv
src/processor_pool_task_scheduler.sv
tb/processor_pool_task_scheduler_tb.sv
